>>> hdl/skl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package skl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int SKIP_STEP   = 8;

  localparam int KEY_W    = 21;
  localparam int TAG_W    = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 8;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

>>> hdl/sorted_key_table_skip_lookup_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   signals                                   direction  payload
// input     in_valid_i / in_ready_o                   in         opcode, code_point, payload_tag
// output    out_valid_o / out_ready_i                 out        status, position, found_tag
//
// one transaction at a time; all work goes through the single read port of the entry ram
// insert: each entry above the new one is shifted up one place, then the new entry is written
// lookup: boundaries are read until one is not below the key, then that block entry by entry
// clear, full insert and unused opcode: straight to the output state
// reset clears the state, the entry count and the valid flags; ram contents past the count are never read
// a finished result waits in the output register while the next transaction is taken

module sorted_key_table_skip_lookup_top #(
  parameter int TableDepth = skl_pkg::TABLE_DEPTH,
  parameter int SkipStep   = skl_pkg::SKIP_STEP
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [skl_pkg::OP_W-1:0]      opcode_i,
  input  wire logic [skl_pkg::KEY_W-1:0]     code_point_i,
  input  wire logic [skl_pkg::TAG_W-1:0]     payload_tag_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [skl_pkg::STATUS_W-1:0]  status_o,
  output logic      [skl_pkg::POS_W-1:0]     position_o,
  output logic      [skl_pkg::TAG_W-1:0]     found_tag_o
);

  localparam int AddrW = $clog2(TableDepth);
  localparam int CntW  = $clog2(TableDepth + 1);
  localparam int PtrW  = $clog2(TableDepth + SkipStep + 1);
  localparam int EntW  = skl_pkg::KEY_W + skl_pkg::TAG_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS_SH  = 3'd1;
  localparam logic [2:0] ST_INS_WR0 = 3'd2;
  localparam logic [2:0] ST_LK_SKIP = 3'd3;
  localparam logic [2:0] ST_LK_BLK  = 3'd4;
  localparam logic [2:0] ST_OUT     = 3'd5;

  logic [2:0]                     state_q, state_d;
  logic [CntW-1:0]                count_q, count_d;
  logic [skl_pkg::KEY_W-1:0]      key_q, key_d;
  logic [skl_pkg::TAG_W-1:0]      tag_q, tag_d;
  logic [AddrW-1:0]               addr_q, addr_d;
  logic [PtrW-1:0]                ptr_q, ptr_d;
  logic [PtrW-1:0]                rptr_q, rptr_d;
  logic [PtrW-1:0]                end_q, end_d;
  logic                           rv_q, rv_d;
  logic [skl_pkg::STATUS_W-1:0]   res_status_q, res_status_d;
  logic [skl_pkg::POS_W-1:0]      res_pos_q, res_pos_d;
  logic [skl_pkg::TAG_W-1:0]      res_tag_q, res_tag_d;
  logic                           out_valid_q, out_valid_d;
  logic [skl_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [skl_pkg::POS_W-1:0]      out_pos_q, out_pos_d;
  logic [skl_pkg::TAG_W-1:0]      out_tag_q, out_tag_d;

  logic                           in_accept;
  logic                           ram_we, ram_re;
  logic [AddrW-1:0]               ram_waddr, ram_raddr;
  logic [EntW-1:0]                ram_wdata, ram_rdata;
  logic [skl_pkg::KEY_W-1:0]      rd_key;
  logic [skl_pkg::TAG_W-1:0]      rd_tag;
  logic [PtrW-1:0]                cnt_ext, cnt_last, blk_last, bnd_addr, blk_end, blk_lim;

  skl_ram #(
    .Width (EntW),
    .Depth (TableDepth)
  ) u_entry_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_we),
    .wr_addr_i (ram_waddr),
    .wr_data_i (ram_wdata),
    .rd_en_i   (ram_re),
    .rd_addr_i (ram_raddr),
    .rd_data_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;

  assign rd_key = ram_rdata[EntW-1:skl_pkg::TAG_W];
  assign rd_tag = ram_rdata[skl_pkg::TAG_W-1:0];

  // block boundary address, clipped at the last entry
  assign cnt_ext  = PtrW'(count_q);
  assign cnt_last = cnt_ext - PtrW'(1);
  assign blk_last = ptr_q + PtrW'(SkipStep - 1);
  assign bnd_addr = (blk_last < cnt_last) ? blk_last : cnt_last;
  assign blk_end  = rptr_q + PtrW'(SkipStep);
  assign blk_lim  = (blk_end < cnt_ext) ? blk_end : cnt_ext;

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    key_d        = key_q;
    tag_d        = tag_q;
    addr_d       = addr_q;
    ptr_d        = ptr_q;
    rptr_d       = rptr_q;
    end_d        = end_q;
    rv_d         = rv_q;
    res_status_d = res_status_q;
    res_pos_d    = res_pos_q;
    res_tag_d    = res_tag_q;
    ram_we       = 1'b0;
    ram_waddr    = addr_q;
    ram_wdata    = {key_q, tag_q};
    ram_re       = 1'b0;
    ram_raddr    = addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          key_d        = code_point_i;
          tag_d        = payload_tag_i;
          res_status_d = skl_pkg::STATUS_OK;
          res_pos_d    = '0;
          res_tag_d    = '0;
          priority if (opcode_i == skl_pkg::OP_INSERT) begin
            priority if (count_q == CntW'(TableDepth)) begin
              res_status_d = skl_pkg::STATUS_FULL;
              state_d      = ST_OUT;
            end else if (count_q == '0) begin
              state_d = ST_INS_WR0;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = AddrW'(count_q - CntW'(1));
              addr_d    = AddrW'(count_q - CntW'(1));
              state_d   = ST_INS_SH;
            end
          end else if (opcode_i == skl_pkg::OP_LOOKUP) begin
            ptr_d   = '0;
            rv_d    = 1'b0;
            state_d = ST_LK_SKIP;
          end else if (opcode_i == skl_pkg::OP_CLEAR) begin
            count_d = '0;
            state_d = ST_OUT;
          end else begin
            state_d = ST_OUT;
          end
        end
      end

      ST_INS_SH: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q + AddrW'(1);
        if (rd_key > key_q) begin
          ram_wdata = ram_rdata;
          if (addr_q == '0) begin
            state_d = ST_INS_WR0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = addr_q - AddrW'(1);
            addr_d    = addr_q - AddrW'(1);
          end
        end else begin
          count_d   = count_q + CntW'(1);
          res_pos_d = skl_pkg::POS_W'(addr_q + AddrW'(1));
          state_d   = ST_OUT;
        end
      end

      ST_INS_WR0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_d   = count_q + CntW'(1);
        res_pos_d = '0;
        state_d   = ST_OUT;
      end

      ST_LK_SKIP: begin
        if (rv_q && (rd_key >= key_q)) begin
          ptr_d   = rptr_q;
          end_d   = blk_lim;
          rv_d    = 1'b0;
          state_d = ST_LK_BLK;
        end else if (ptr_q < cnt_ext) begin
          ram_re    = 1'b1;
          ram_raddr = bnd_addr[AddrW-1:0];
          rptr_d    = ptr_q;
          ptr_d     = ptr_q + PtrW'(SkipStep);
          rv_d      = 1'b1;
        end else if (rv_q) begin
          rv_d = 1'b0;
        end else begin
          res_status_d = skl_pkg::STATUS_MISS;
          state_d      = ST_OUT;
        end
      end

      ST_LK_BLK: begin
        if (rv_q && (rd_key == key_q)) begin
          res_pos_d = skl_pkg::POS_W'(rptr_q);
          res_tag_d = rd_tag;
          state_d   = ST_OUT;
        end else if (ptr_q < end_q) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_q[AddrW-1:0];
          rptr_d    = ptr_q;
          ptr_d     = ptr_q + PtrW'(1);
          rv_d      = 1'b1;
        end else if (rv_q) begin
          rv_d = 1'b0;
        end else begin
          res_status_d = skl_pkg::STATUS_MISS;
          state_d      = ST_OUT;
        end
      end

      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_pos_d    = out_pos_q;
    out_tag_d    = out_tag_q;
    if ((state_q == ST_OUT) && (!out_valid_q || out_ready_i)) begin
      out_valid_d  = 1'b1;
      out_status_d = res_status_q;
      out_pos_d    = res_pos_q;
      out_tag_d    = res_tag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    tag_q        <= tag_d;
    addr_q       <= addr_d;
    ptr_q        <= ptr_d;
    rptr_q       <= rptr_d;
    end_q        <= end_d;
    res_status_q <= res_status_d;
    res_pos_q    <= res_pos_d;
    res_tag_q    <= res_tag_d;
    out_status_q <= out_status_d;
    out_pos_q    <= out_pos_d;
    out_tag_q    <= out_tag_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign position_o  = out_pos_q;
  assign found_tag_o = out_tag_q;

  a_full_keeps_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (opcode_i == skl_pkg::OP_INSERT) && (count_q == CntW'(TableDepth)))
    |=> (count_q == $past(count_q)))
    else $error("insert into full table changed the entry count");

  a_clear_empties : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (opcode_i == skl_pkg::OP_CLEAR)) |=> (count_q == '0))
    else $error("clear did not empty the table");

  a_write_in_insert : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (((state_q == ST_INS_SH) || (state_q == ST_INS_WR0))
                && (CntW'(ram_waddr) <= count_q)))
    else $error("entry ram written outside an insert or past the count");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == skl_pkg::STATUS_MISS))
    |-> ((position_o == '0) && (found_tag_o == '0)))
    else $error("miss result carries a position or tag");

endmodule

`default_nettype wire

>>> hdl/skl_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module skl_ram #(
  parameter int Width = 29,
  parameter int Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic      [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire
